/* rtl/fcal_pkg.sv */
// Shared types, request codes and status codes for the fixed-capacity list unit.
package fcal_pkg;

    // Default capacity and the most entries one list request reports
    localparam int DEPTH_DEF = 8;
    localparam int LIST_MAX  = 8;

    // Request codes carried on func
    typedef enum logic [2:0] {
        FN_INS_HEAD = 3'd0,
        FN_APPEND   = 3'd1,
        FN_INS_POS  = 3'd2,
        FN_DEL_TAIL = 3'd3,
        FN_DEL_POS  = 3'd4,
        FN_DEL_VAL  = 3'd5,
        FN_UPD_VAL  = 3'd6,
        FN_LIST     = 3'd7
    } func_t;

    // Status codes carried on status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_HOLD    = 3'd0,
        OP_INSERT  = 3'd1,
        OP_DEL_POS = 3'd2,
        OP_DEL_HIT = 3'd3,
        OP_UPDATE  = 3'd4,
        OP_ROTATE  = 3'd5
    } cell_op_t;

endpackage

/* rtl/fcal_cell.sv */
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
module fcal_cell
    import fcal_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 4
)
(
    input  logic                clk,
    input  cell_op_t            op,
    input  logic [CW-1:0]       pos,
    input  logic [CW-1:0]       count,
    input  logic signed [31:0]  left_val,
    input  logic signed [31:0]  right_val,
    input  logic signed [31:0]  head_val,
    input  logic signed [31:0]  value,
    input  logic signed [31:0]  new_value,
    input  logic                hit_in,
    output logic signed [31:0]  entry_val,
    output logic                hit_out,
    output logic                first_hit
);

    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               in_list;
    logic               match;

    // Flag a valid entry equal to the searched value; pass the hit along the chain
    assign in_list   = MY_IDX < count;
    assign match     = in_list && (entry_reg == value);
    assign hit_out   = hit_in | match;
    assign first_hit = match & ~hit_in;
    assign entry_val = entry_reg;

    // Pick the next entry from the broadcast operation
    always_comb
    begin
        entry_next = entry_reg;
        case (op)
            OP_INSERT:
            begin
                if (MY_IDX == pos)
                    entry_next = value;
                else if (MY_IDX > pos && MY_IDX <= count)
                    entry_next = left_val;
            end
            OP_DEL_POS:
            begin
                if (MY_IDX >= pos && MY_NEXT < count)
                    entry_next = right_val;
            end
            OP_DEL_HIT:
            begin
                if ((hit_in | match) && MY_NEXT < count)
                    entry_next = right_val;
            end
            OP_UPDATE:
            begin
                if (first_hit)
                    entry_next = new_value;
            end
            OP_ROTATE:
            begin
                if (MY_NEXT == count)
                    entry_next = head_val;
                else if (MY_NEXT < count)
                    entry_next = right_val;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/fixed_capacity_array_list_unit.sv */
// Fixed-capacity ordered list: a chain of entry cells with a count and a result register.
// Edit requests (func 0 to 6): one result strobed the cycle after start; one per cycle if idle.
// List request: one result per entry (at most LIST_MAX), first the cycle after start;
//   results come on consecutive cycles as the chain rotates once per cycle; busy stays
//   high until it has rotated once per entry (an empty list gives one ST_EMPTY result).
// Results cannot be held off; each is shown for one cycle on result_valid.
// Reset (rst_n low, asynchronous) empties the list; entry contents are left as they are.
module fixed_capacity_array_list_unit
    import fcal_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          func,
    input  logic [3:0]          position,
    input  logic signed [31:0]  value,
    input  logic signed [31:0]  new_value,
    output logic                result_valid,
    output logic [2:0]          status,
    output logic [2:0]          entry_index,
    output logic signed [31:0]  entry_value,
    output logic                last
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PW  = (CW > 4) ? CW : 4;
    localparam int IW0 = $clog2(DEPTH);
    localparam int IW  = (IW0 > 0) ? IW0 : 1;
    localparam int XW  = (IW > 3) ? IW : 3;

    logic [CW-1:0]      count_reg, count_next;
    logic               busy_reg, busy_next;
    logic [CW-1:0]      k_reg, k_next;
    logic               valid_reg, valid_next;
    logic [2:0]         status_reg, status_next;
    logic [2:0]         index_reg, index_next;
    logic signed [31:0] value_reg, value_next;
    logic               last_reg, last_next;

    logic               accept;
    func_t              fn;
    cell_op_t           op;
    logic [CW-1:0]      cell_pos;
    logic [PW-1:0]      c_ext, p_ext, k_ext, lim;
    logic [CW-1:0]      k_cur;
    logic               full, empty, found, list_step;
    logic [IW-1:0]      where_idx;
    logic [XW-1:0]      where_ext, k_idx_ext;

    logic signed [31:0] cell_val [DEPTH];
    logic               hit_chain [DEPTH+1];
    logic [DEPTH-1:0]   first_vec;

    assign accept = start & ~busy_reg;
    assign fn     = func_t'(func);
    assign c_ext  = PW'(count_reg);
    assign p_ext  = PW'(position);
    assign full   = count_reg == CW'(DEPTH);
    assign empty  = count_reg == '0;
    assign found  = hit_chain[DEPTH];
    assign hit_chain[0] = 1'b0;

    // Build the chain of entry cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] left_v, right_v;
        if (i == 0)
        begin : g_l0
            assign left_v = '0;
        end
        else
        begin : g_ln
            assign left_v = cell_val[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_rl
            assign right_v = '0;
        end
        else
        begin : g_rn
            assign right_v = cell_val[i+1];
        end

        fcal_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk       (clk),
            .op        (op),
            .pos       (cell_pos),
            .count     (count_reg),
            .left_val  (left_v),
            .right_val (right_v),
            .head_val  (cell_val[0]),
            .value     (value),
            .new_value (new_value),
            .hit_in    (hit_chain[i]),
            .entry_val (cell_val[i]),
            .hit_out   (hit_chain[i+1]),
            .first_hit (first_vec[i])
        );
    end

    // Encode the index of the first matching cell
    always_comb
    begin
        where_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_vec[i])
                where_idx = where_idx | IW'(i);
        end
    end

    assign where_ext = XW'(where_idx);

    // Listing: rotate the chain once per cycle and report cell zero
    assign list_step = busy_reg | (accept && fn == FN_LIST && !empty);
    assign k_cur     = busy_reg ? k_reg : '0;
    assign k_ext     = PW'(k_cur);
    assign k_idx_ext = XW'(k_cur);
    assign lim       = (c_ext > PW'(LIST_MAX)) ? PW'(LIST_MAX) : c_ext;

    // Decode the request into a cell operation, a status and the next count
    always_comb
    begin
        op          = OP_HOLD;
        cell_pos    = '0;
        count_next  = count_reg;
        busy_next   = busy_reg;
        k_next      = k_reg;
        valid_next  = 1'b0;
        status_next = ST_OK;
        index_next  = '0;
        value_next  = '0;
        last_next   = 1'b1;

        if (list_step)
        begin
            op         = OP_ROTATE;
            k_next     = k_cur + CW'(1);
            busy_next  = (k_ext + PW'(1)) != c_ext;
            valid_next = k_ext < lim;
            index_next = k_idx_ext[2:0];
            value_next = cell_val[0];
            last_next  = (k_ext + PW'(1)) == lim;
        end
        else if (accept)
        begin
            valid_next = 1'b1;
            unique case (fn) inside
                FN_INS_HEAD, FN_APPEND, FN_INS_POS:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else if (fn == FN_INS_POS && p_ext > c_ext)
                        status_next = ST_BADPOS;
                    else
                    begin
                        op         = OP_INSERT;
                        count_next = count_reg + CW'(1);
                        if (fn == FN_APPEND)
                            cell_pos = count_reg;
                        else if (fn == FN_INS_POS)
                            cell_pos = p_ext[CW-1:0];
                        else
                            cell_pos = '0;
                    end
                end
                FN_DEL_TAIL:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                        count_next = count_reg - CW'(1);
                end
                FN_DEL_POS:
                begin
                    if (p_ext >= c_ext)
                        status_next = ST_BADPOS;
                    else
                    begin
                        op         = OP_DEL_POS;
                        cell_pos   = p_ext[CW-1:0];
                        count_next = count_reg - CW'(1);
                    end
                end
                FN_DEL_VAL, FN_UPD_VAL:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (!found)
                        status_next = ST_NOTFOUND;
                    else if (fn == FN_DEL_VAL)
                    begin
                        op         = OP_DEL_HIT;
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        op         = OP_UPDATE;
                        index_next = where_ext[2:0];
                    end
                end
                default:
                begin
                    // list of an empty chain
                    status_next = ST_EMPTY;
                end
            endcase
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload for its transaction
    always_ff @(posedge clk)
    begin
        if (valid_next)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
            value_reg  <= value_next;
            last_reg   <= last_next;
        end
    end

    assign busy         = busy_reg;
    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign entry_index  = index_reg;
    assign entry_value  = value_reg;
    assign last         = last_reg;

endmodule

/* rtl/fcal_checker.sv */
// Port-level checker for the list unit, bound to the top level.
module fcal_checker
    import fcal_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input logic [2:0]   func,
    input logic         result_valid,
    input logic [2:0]   status,
    input logic         last
);

    // An edit transaction answers the next cycle with a single final result
    a_edit_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func != FN_LIST |=> result_valid && last)
        else $error("edit transaction gave no final result");

    // A list transaction answers the next cycle
    a_list_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func == FN_LIST |=> result_valid)
        else $error("list transaction gave no result");

    // A listing run has no gaps
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid)
        else $error("listing run broken");

    // More results pending means the unit is busy
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("listing run while not busy");

    // An error status always closes the request
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_OK |-> last)
        else $error("error status not final");

endmodule

bind fixed_capacity_array_list_unit fcal_checker u_fcal_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .result_valid (result_valid),
    .status       (status),
    .last         (last)
);
